FILE: hw/rtl/nrpi_pkg.sv
// Types, knot tables and constants of the neon radiation power interpolator.
`timescale 1ns / 1ps
`default_nettype none
package nrpi_pkg;

  localparam int unsigned NUM_KNOTS  = 91;
  localparam int unsigned KNOT_IDX_W = $clog2(NUM_KNOTS);
  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned TEMP_W     = 22;
  localparam int unsigned RHO_W      = 32;
  localparam int unsigned POWER_W    = 64;
  localparam int unsigned ZQ_W       = 24;
  localparam int unsigned LQ_W       = 49;
  localparam int unsigned LI_W       = 48;
  localparam int unsigned SUM_W      = 160;
  localparam int unsigned ROUND_BIT  = 77;
  localparam int unsigned OUT_LSB    = 78;
  localparam int unsigned SAT_LSB    = OUT_LSB + POWER_W;
  localparam logic [31:0] POWER_SCALE = 32'd3285552265;

  typedef struct packed {
    logic [RHO_W-1:0]  mass_density;
    logic [TEMP_W-1:0] temperature;
  } in_t;

  typedef struct packed {
    logic [POWER_W-1:0] power_density;
    logic               below_table;
    logic               saturated;
  } out_t;

  typedef struct packed {
    logic                   below;
    logic [ZQ_W-1:0]        zlo;
    logic signed [ZQ_W:0]   zdf;
    logic [LQ_W-1:0]        llo;
    logic signed [LQ_W:0]   ldf;
    logic [FRAC_BITS:0]     frac;
  } seg_t;

  typedef logic [31:0]     z_raw_t [NUM_KNOTS];
  typedef logic [63:0]     l_raw_t [NUM_KNOTS];
  typedef logic [ZQ_W-1:0] z_tab_t [NUM_KNOTS];
  typedef logic [LQ_W-1:0] l_tab_t [NUM_KNOTS];

  function automatic logic [63:0] lk(input logic [63:0] m, input int e);
    logic [63:0] r;
    r = m;
    for (int i = 0; i < e; i++) begin
      r = r * 64'd10;
    end
    return r;
  endfunction

  // Z knots in units of 1e-8
  localparam z_raw_t Z_RAW = '{
    2855628, 1463662*10, 4330838*10, 7347827*10, 8955859*10,
    9587141*10, 9825625*10, 9920914*10, 9962807*10, 9985018*10,
    1000286*100, 1002707*100, 1006990*100, 1014886*100, 1028927*100,
    1052489*100, 1089469*100, 1143327*100, 1215524*100, 1303975*100,
    1402701*100, 1503367*100, 1597987*100, 1681105*100, 1750426*100,
    1806171*100, 1849998*100, 1884091*100, 1910620*100, 1931495*100,
    1948310*100, 1962368*100, 1974739*100, 1986323*100, 1997900*100,
    2010166*100, 2023761*100, 2039274*100, 2057237*100, 2078115*100,
    2102280*100, 2275239*100, 2498072*100, 2690690*100, 2819845*100,
    2900079*100, 2954544*100, 3000644*100, 3049845*100, 3109150*100,
    3181565*100, 3266204*100, 3358960*100, 3454218*100, 3546805*100,
    3633317*100, 3712484*100, 3784763*100, 3851660*100, 3915086*100,
    3976912*100, 4038694*100, 4101567*100, 4166216*100, 4232939*100,
    4301736*100, 4372415*100, 4444695*100, 4518282*100, 4592917*100,
    4668399*100, 4744582*100, 4821367*100, 4898686*100, 4976481*100,
    5054694*100, 5133261*100, 5212099*100, 5291106*100, 5370152*100,
    5449081*100, 5527706*100, 5605804*100, 5683127*100, 5759401*100,
    5834343*100, 5907667*100, 5979103*100, 6048405*100, 6115366*100,
    6179824*100
  };

  // L knots in units of 1e-23
  localparam l_raw_t L_RAW = '{
    lk(1294421,0), lk(5032943,0), lk(1175009,1), lk(1618292,1), lk(1633444,1),
    lk(1487624,1), lk(1340048,1), lk(1251299,1), lk(1267496,1), lk(1459262,1),
    lk(1946532,1), lk(2921758,1), lk(4680815,1), lk(7667701,1), lk(1254301,2),
    lk(2028582,2), lk(3232404,2), lk(5064973,2), lk(7782106,2), lk(1167420,3),
    lk(1702276,3), lk(2405655,3), lk(3293476,3), lk(4376405,3), lk(5663246,3),
    lk(7163800,3), lk(8890362,3), lk(1085818,4), lk(1308546,4), lk(1559355,4),
    lk(1840726,4), lk(2155569,4), lk(2507330,4), lk(2900121,4), lk(3338860,4),
    lk(3829394,4), lk(4378594,4), lk(4993941,4), lk(5685169,4), lk(6461584,4),
    lk(7333081,4), lk(1340709,5), lk(2244150,5), lk(3337638,5), lk(4502229,5),
    lk(5694331,5), lk(6914699,5), lk(8175398,5), lk(9488725,5), lk(1086383,6),
    lk(1230390,6), lk(1380364,6), lk(1534886,6), lk(1691982,6), lk(1849633,6),
    lk(2006210,6), lk(2160670,6), lk(2312510,6), lk(2461607,6), lk(2608032,6),
    lk(2751923,6), lk(2893380,6), lk(3032439,6), lk(3169057,6), lk(3303126,6),
    lk(3434488,6), lk(3562955,6), lk(3688312,6), lk(3810312,6), lk(3928663,6),
    lk(4043005,6), lk(4152896,6), lk(4257794,6), lk(4357054,6), lk(4449942,6),
    lk(4535653,6), lk(4613346,6), lk(4682193,6), lk(4741422,6), lk(4790376,6),
    lk(4828558,6), lk(4855674,6), lk(4871657,6), lk(4876686,6), lk(4871173,6),
    lk(4855750,6), lk(4831223,6), lk(4798535,6), lk(4758706,6), lk(4712785,6),
    lk(4661804,6)
  };

  function automatic z_tab_t build_z();
    z_tab_t r;
    for (int i = 0; i < NUM_KNOTS; i++) begin
      r[i] = ZQ_W'((64'(Z_RAW[i]) * 64'd2097152 + 64'd50000000) / 64'd100000000);
    end
    return r;
  endfunction

  function automatic l_tab_t build_l();
    l_tab_t r;
    for (int i = 0; i < NUM_KNOTS; i++) begin
      r[i] = LQ_W'((L_RAW[i] + 64'd500) / 64'd1000);
    end
    return r;
  endfunction

  localparam z_tab_t Z_Q = build_z();
  localparam l_tab_t L_Q = build_l();

endpackage
`default_nettype wire

FILE: hw/rtl/nrpi_seg.sv
// Segment select and knot lookup for one temperature.
`timescale 1ns / 1ps
`default_nettype none
module nrpi_seg
  import nrpi_pkg::*;
(
  input  logic [TEMP_W-1:0] temperature_i,
  output seg_t              seg_o
);

  localparam logic [KNOT_IDX_W-1:0] LAST_SEG = KNOT_IDX_W'(NUM_KNOTS - 2);
  localparam logic [FRAC_BITS:0]    FRAC_ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;
  localparam int unsigned INT_W = TEMP_W - FRAC_BITS;
  localparam int unsigned X10_W = TEMP_W + 4;

  logic [INT_W-1:0]         t_int;
  logic [X10_W-1:0]         x10;
  logic [X10_W-FRAC_BITS-1:0] x10_int;
  logic [KNOT_IDX_W-1:0]    j_lo;
  logic [KNOT_IDX_W-1:0]    j_hi;
  logic [KNOT_IDX_W-1:0]    j;
  logic [KNOT_IDX_W-1:0]    j1;
  logic [FRAC_BITS:0]       frac;
  logic [ZQ_W-1:0]          zhi;
  logic [LQ_W-1:0]          lhi;

  assign t_int   = temperature_i[TEMP_W-1:FRAC_BITS];
  assign x10     = X10_W'({temperature_i, 3'b000}) + X10_W'({temperature_i, 1'b0});
  assign x10_int = x10[X10_W-1:FRAC_BITS];
  assign j_lo    = KNOT_IDX_W'(x10_int - (X10_W-FRAC_BITS)'(10));
  assign j_hi    = KNOT_IDX_W'(temperature_i[TEMP_W-1:FRAC_BITS-1]) + KNOT_IDX_W'(30);

  always_comb begin
    priority if (t_int >= INT_W'(30)) begin
      j    = LAST_SEG;
      frac = FRAC_ONE;
    end else if (t_int < INT_W'(5)) begin
      j    = j_lo;
      frac = {1'b0, x10[FRAC_BITS-1:0]};
    end else begin
      j    = j_hi;
      frac = {1'b0, temperature_i[FRAC_BITS-2:0], 1'b0};
    end
  end

  assign j1  = j + KNOT_IDX_W'(1);
  assign zhi = Z_Q[j1];
  assign lhi = L_Q[j1];

  always_comb begin
    seg_o.below = (t_int == '0);
    seg_o.zlo   = Z_Q[j];
    seg_o.llo   = L_Q[j];
    seg_o.zdf   = $signed({1'b0, zhi}) - $signed({1'b0, Z_Q[j]});
    seg_o.ldf   = $signed({1'b0, lhi}) - $signed({1'b0, L_Q[j]});
    seg_o.frac  = frac;
  end

endmodule
`default_nettype wire

FILE: hw/rtl/neon_radiation_power_interp_unit.sv
// Top level: pipelined neon radiation power density interpolator.
//
//  channel | dir | handshake        | payload
//  --------+-----+------------------+-------------------------------------
//  in      | in  | valid_i, stall_o | data_i: mass_density, temperature
//  out     | out | valid_o, stall_i | data_o: power_density, flags
//
// Eight register stages: one item per cycle while the output is not stalled.
// Stage split: lookup and rho squared, interpolation, two steps for Z*L,
// two for the 64x64 product, one for the scale partial products, and one
// to sum, round and clamp.
// Reset clears the valid bits only. A stall_i on a valid output freezes every stage.
`timescale 1ns / 1ps
`default_nettype none
module neon_radiation_power_interp_unit
  import nrpi_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic stall_o,
  input  in_t  data_i,
  output logic valid_o,
  input  logic stall_i,
  output out_t data_o
);

  localparam int unsigned NSTG = 8;

  logic            en;
  logic [NSTG:1]   v_q;
  logic [NSTG-1:1] below_q;
  seg_t            seg;

  logic [ZQ_W-1:0]      s1_zlo_q;
  logic signed [ZQ_W:0] s1_zdf_q;
  logic [LQ_W-1:0]      s1_llo_q;
  logic signed [LQ_W:0] s1_ldf_q;
  logic [FRAC_BITS:0]   s1_frac_q;
  logic [63:0]          rr_d;
  logic [63:0]          rr_q [1:4];

  logic signed [ZQ_W+FRAC_BITS+1:0]     zprod;
  logic signed [ZQ_W+FRAC_BITS+3:0]     zacc;
  logic signed [LQ_W+FRAC_BITS+1:0]     lprod;
  logic signed [LQ_W+FRAC_BITS+2:0]     lacc;
  logic [ZQ_W-1:0]                      s2_zi_q;
  logic [LI_W-1:0]                      s2_li_q;

  logic [ZQ_W+31:0]   s3_pa_q;
  logic [ZQ_W+15:0]   s3_pb_q;
  logic [63:0]        s4_zl_q;
  logic [63:0]        s5_pp_q [4];
  logic [127:0]       s6_p_q;
  logic [63:0]        s7_q_q [4];
  logic [SUM_W-1:0]   sum;
  out_t               out_q;

  assign en      = !(v_q[NSTG] && stall_i);
  assign stall_o = !en;
  assign valid_o = v_q[NSTG];
  assign data_o  = out_q;

  nrpi_seg u_seg (
    .temperature_i (data_i.temperature),
    .seg_o         (seg)
  );

  assign rr_d  = 64'(data_i.mass_density) * 64'(data_i.mass_density);
  assign zprod = (ZQ_W+FRAC_BITS+2)'(s1_zdf_q)
               * (ZQ_W+FRAC_BITS+2)'($signed({1'b0, s1_frac_q}));
  assign zacc  = $signed({4'b0000, s1_zlo_q, FRAC_BITS'(0)}) + (ZQ_W+FRAC_BITS+4)'(zprod)
               + (ZQ_W+FRAC_BITS+4)'(1 << (FRAC_BITS-1));
  assign lprod = (LQ_W+FRAC_BITS+2)'(s1_ldf_q)
               * (LQ_W+FRAC_BITS+2)'($signed({1'b0, s1_frac_q}));
  assign lacc  = $signed({3'b000, s1_llo_q, FRAC_BITS'(0)}) + (LQ_W+FRAC_BITS+3)'(lprod)
               + (LQ_W+FRAC_BITS+3)'(1 << (FRAC_BITS-1));
  assign sum   = {96'b0, s7_q_q[0]} + {64'b0, s7_q_q[1], 32'b0}
               + {32'b0, s7_q_q[2], 64'b0} + {s7_q_q[3], 96'b0}
               + (SUM_W'(1) << ROUND_BIT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NSTG-1:1], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      below_q   <= {below_q[NSTG-2:1], seg.below};
      s1_zlo_q  <= seg.zlo;
      s1_zdf_q  <= seg.zdf;
      s1_llo_q  <= seg.llo;
      s1_ldf_q  <= seg.ldf;
      s1_frac_q <= seg.frac;
      rr_q[1]   <= rr_d;
      rr_q[2]   <= rr_q[1];
      rr_q[3]   <= rr_q[2];
      rr_q[4]   <= rr_q[3];
      s2_zi_q   <= zacc[ZQ_W+FRAC_BITS-1:FRAC_BITS];
      s2_li_q   <= lacc[63:FRAC_BITS];
      s3_pa_q   <= (ZQ_W+32)'(s2_zi_q) * (ZQ_W+32)'(s2_li_q[31:0]);
      s3_pb_q   <= (ZQ_W+16)'(s2_zi_q) * (ZQ_W+16)'(s2_li_q[47:32]);
      s4_zl_q   <= 64'(s3_pa_q) + {s3_pb_q[31:0], 32'b0};
      s5_pp_q[0] <= 64'(rr_q[4][31:0])  * 64'(s4_zl_q[31:0]);
      s5_pp_q[1] <= 64'(rr_q[4][31:0])  * 64'(s4_zl_q[63:32]);
      s5_pp_q[2] <= 64'(rr_q[4][63:32]) * 64'(s4_zl_q[31:0]);
      s5_pp_q[3] <= 64'(rr_q[4][63:32]) * 64'(s4_zl_q[63:32]);
      s6_p_q    <= {64'b0, s5_pp_q[0]} + {32'b0, s5_pp_q[1], 32'b0}
                 + {32'b0, s5_pp_q[2], 32'b0} + {s5_pp_q[3], 64'b0};
      for (int k = 0; k < 4; k++) begin
        s7_q_q[k] <= 64'(s6_p_q[32*k +: 32]) * 64'(POWER_SCALE);
      end
      if (below_q[NSTG-1]) begin
        out_q.power_density <= '0;
        out_q.below_table   <= 1'b1;
        out_q.saturated     <= 1'b0;
      end else if (sum[SUM_W-1:SAT_LSB] != '0) begin
        out_q.power_density <= '1;
        out_q.below_table   <= 1'b0;
        out_q.saturated     <= 1'b1;
      end else begin
        out_q.power_density <= sum[SAT_LSB-1:OUT_LSB];
        out_q.below_table   <= 1'b0;
        out_q.saturated     <= 1'b0;
      end
    end
  end

  a_below_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && data_o.below_table |-> data_o.power_density == '0 && !data_o.saturated)
    else $error("below-table item carries nonzero power");

  a_sat_ones: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && data_o.saturated |-> data_o.power_density == '1)
    else $error("saturated item not clamped");

  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !stall_o |=> v_q[1])
    else $error("accepted item lost at entry");

  a_hold_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |=> v_q == $past(v_q))
    else $error("pipeline moved while stalled");

endmodule
`default_nettype wire
